>>> rtl/kbs_pkg.sv
package kbs_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_PEEK   = 3'd2,
    CMD_LOOKUP = 3'd3,
    CMD_SET    = 3'd4,
    CMD_ADD    = 3'd5,
    CMD_SUB    = 3'd6
  } kbs_cmd_e;

  typedef enum logic [3:0] {
    ST_OK      = 4'd0,
    ST_DUP     = 4'd1,
    ST_BADCAT  = 4'd2,
    ST_FULL    = 4'd3,
    ST_EMPTY   = 4'd4,
    ST_MISSING = 4'd5,
    ST_NEGVAL  = 4'd6,
    ST_NEGRES  = 4'd7,
    ST_OVF     = 4'd8
  } kbs_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_REPLY
  } kbs_state_e;

  // register index = paddr[2]
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_MASK     = 1'b1;

  localparam logic [6:0] CAPACITY_RST = 7'd64;
  localparam logic [3:0] MASK_RST     = 4'd7;

  localparam logic signed [31:0] QTY_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic [1:0]         cat;
    logic signed [31:0] qty;
    logic [31:0]        price;
  } kbs_entry_t;

  // search request walking down the cell row
  typedef struct packed {
    logic               active;
    kbs_cmd_e           cmd;
    logic signed [31:0] amount;
    logic               found;
    kbs_entry_t         ent;
    logic               ovf;
    logic               negres;
  } kbs_tok_t;

  typedef struct packed {
    logic dn;
    logic up;
  } kbs_shift_t;

  typedef struct packed {
    logic [6:0] capacity;
    logic [3:0] mask;
  } kbs_cfg_t;

endpackage

>>> rtl/keyed_bounded_stack_core.sv
// Channel  Handshake         Payload
// in       in_valid_i/stall  cmd_i, item_key_i, category_code_i, amount_i, unit_price_i
// out      out_valid_o/stall status_o, entry_key_o, entry_category_o, entry_quantity_o,
//                            entry_price_o, in_stock_o, entry_count_o
// cfg      APB (psel...)     capacity at 0x0, category_mask at 0x4
//
// Push, lookup and quantity updates search the cell row before the result:
// the search request walks the cell row one cell per cycle, top of stack first.
// Pop, peek and the unused code skip the search. One request at a time; the next is
// taken once the result sits in the output register.
// Reset empties the stack and loads capacity 64, mask 7. While a result is stalled,
// the next result waits in the reply state until the stalled one is taken.
module keyed_bounded_stack_core #(
  parameter int DEPTH    = 64,
  parameter int KEY_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         cmd_i,
  input  logic [15:0]        item_key_i,
  input  logic [1:0]         category_code_i,
  input  logic signed [31:0] amount_i,
  input  logic [31:0]        unit_price_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [3:0]         status_o,
  output logic [15:0]        entry_key_o,
  output logic [1:0]         entry_category_o,
  output logic signed [31:0] entry_quantity_o,
  output logic [31:0]        entry_price_o,
  output logic               in_stock_o,
  output logic [6:0]         entry_count_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import kbs_pkg::*;

  localparam int FILL_W = $clog2(DEPTH + 1);

  kbs_cfg_t   cfg_q;
  logic       cfg_wr;

  logic [FILL_W-1:0]   fill;
  kbs_shift_t          shift;
  logic [KEY_BITS-1:0] new_key;
  kbs_entry_t          new_ent;
  kbs_tok_t            head_tok;
  logic [KEY_BITS-1:0] head_tok_key;

  logic [KEY_BITS-1:0] key_w     [DEPTH];
  kbs_entry_t          ent_w     [DEPTH];
  kbs_tok_t            tok_w     [DEPTH];
  logic [KEY_BITS-1:0] tok_key_w [DEPTH];

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.capacity <= CAPACITY_RST;
      cfg_q.mask     <= MASK_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_CAPACITY: cfg_q.capacity <= pwdata[6:0];
        REG_MASK:     cfg_q.mask     <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_CAPACITY: prdata = 32'(cfg_q.capacity);
      REG_MASK:     prdata = 32'(cfg_q.mask);
      default:      prdata = '0;
    endcase
  end

  kbs_ctrl #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS),
    .FILL_W   (FILL_W)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cmd_i            (cmd_i),
    .item_key_i       (item_key_i),
    .category_code_i  (category_code_i),
    .amount_i         (amount_i),
    .unit_price_i     (unit_price_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .entry_key_o      (entry_key_o),
    .entry_category_o (entry_category_o),
    .entry_quantity_o (entry_quantity_o),
    .entry_price_o    (entry_price_o),
    .in_stock_o       (in_stock_o),
    .entry_count_o    (entry_count_o),
    .fill_o           (fill),
    .shift_o          (shift),
    .new_key_o        (new_key),
    .new_ent_o        (new_ent),
    .top_key_i        (key_w[0]),
    .top_ent_i        (ent_w[0]),
    .tok_o            (head_tok),
    .tok_key_o        (head_tok_key),
    .tail_tok_i       (tok_w[DEPTH-1])
  );

  // cell 0 holds the top of the stack
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_BITS-1:0] prev_key, next_key, in_tok_key;
    kbs_entry_t          prev_ent, next_ent;
    kbs_tok_t            in_tok;

    if (i == 0) begin : g_head
      assign prev_key   = new_key;
      assign prev_ent   = new_ent;
      assign in_tok     = head_tok;
      assign in_tok_key = head_tok_key;
    end else begin : g_body
      assign prev_key   = key_w[i-1];
      assign prev_ent   = ent_w[i-1];
      assign in_tok     = tok_w[i-1];
      assign in_tok_key = tok_key_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_key = key_w[i];
      assign next_ent = ent_w[i];
    end else begin : g_mid
      assign next_key = key_w[i+1];
      assign next_ent = ent_w[i+1];
    end

    kbs_cell #(
      .KEY_BITS (KEY_BITS),
      .FILL_W   (FILL_W),
      .INDEX    (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .fill_i     (fill),
      .shift_i    (shift),
      .prev_key_i (prev_key),
      .prev_ent_i (prev_ent),
      .next_key_i (next_key),
      .next_ent_i (next_ent),
      .key_o      (key_w[i]),
      .ent_o      (ent_w[i]),
      .tok_i      (in_tok),
      .tok_key_i  (in_tok_key),
      .tok_o      (tok_w[i]),
      .tok_key_o  (tok_key_w[i])
    );
  end

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted but block not busy");

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill) <= 32'(DEPTH))
    else $error("fill level beyond depth");

  a_fill_moves_with_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill != $past(fill)) |-> out_valid_o)
    else $error("fill level changed without a result");

  a_reject_no_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_DUP || status_o == ST_BADCAT || status_o == ST_FULL ||
     status_o == ST_EMPTY || status_o == ST_MISSING))
    |-> (entry_key_o == '0 && entry_price_o == '0 && !in_stock_o))
    else $error("rejected request reports an entry");

endmodule

>>> rtl/kbs_cell.sv
module kbs_cell #(
  parameter int KEY_BITS = 16,
  parameter int FILL_W   = 7,
  parameter int INDEX    = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [FILL_W-1:0]     fill_i,
  input  kbs_pkg::kbs_shift_t   shift_i,
  input  logic [KEY_BITS-1:0]   prev_key_i,
  input  kbs_pkg::kbs_entry_t   prev_ent_i,
  input  logic [KEY_BITS-1:0]   next_key_i,
  input  kbs_pkg::kbs_entry_t   next_ent_i,
  output logic [KEY_BITS-1:0]   key_o,
  output kbs_pkg::kbs_entry_t   ent_o,
  input  kbs_pkg::kbs_tok_t     tok_i,
  input  logic [KEY_BITS-1:0]   tok_key_i,
  output kbs_pkg::kbs_tok_t     tok_o,
  output logic [KEY_BITS-1:0]   tok_key_o
);
  import kbs_pkg::*;

  localparam logic [FILL_W-1:0] Slot = FILL_W'(INDEX);

  logic [KEY_BITS-1:0] key_q, key_d;
  kbs_entry_t          ent_q, ent_d;
  kbs_tok_t            tok_q, tok_d;
  logic [KEY_BITS-1:0] tok_key_q;
  logic                tok_act_q;

  logic               in_use, hit, neg_amt, wr;
  logic [32:0]        sum, diff;
  logic               sum_ovf, diff_neg;
  logic signed [31:0] new_qty;
  logic               ovf_flag, negres_flag, upd_cmd;

  always_comb begin
    in_use   = Slot < fill_i;
    hit      = tok_i.active && in_use && !tok_i.found && (key_q == tok_key_i);
    neg_amt  = tok_i.amount[31];
    sum      = {ent_q.qty[31], ent_q.qty} + {tok_i.amount[31], tok_i.amount};
    diff     = {ent_q.qty[31], ent_q.qty} - {tok_i.amount[31], tok_i.amount};
    // positive result past the signed maximum
    sum_ovf  = !sum[32] && sum[31];
    diff_neg = diff[32];

    new_qty     = ent_q.qty;
    ovf_flag    = 1'b0;
    negres_flag = 1'b0;
    upd_cmd     = 1'b0;
    unique case (tok_i.cmd)
      CMD_SET: begin
        new_qty = tok_i.amount;
        upd_cmd = 1'b1;
      end
      CMD_ADD: begin
        new_qty  = sum_ovf ? QTY_MAX : sum[31:0];
        ovf_flag = sum_ovf;
        upd_cmd  = 1'b1;
      end
      CMD_SUB: begin
        negres_flag = diff_neg;
        new_qty     = diff_neg ? ent_q.qty : diff[31:0];
        upd_cmd     = !diff_neg;
      end
      default: ;
    endcase

    wr = hit && !neg_amt && upd_cmd;

    tok_d = tok_i;
    if (hit) begin
      tok_d.found      = 1'b1;
      tok_d.ent.cat    = ent_q.cat;
      tok_d.ent.price  = ent_q.price;
      tok_d.ent.qty    = wr ? new_qty : ent_q.qty;
      tok_d.ovf        = ovf_flag && !neg_amt;
      tok_d.negres     = negres_flag && !neg_amt;
    end

    priority if (shift_i.dn) begin
      key_d = prev_key_i;
      ent_d = prev_ent_i;
    end else if (shift_i.up) begin
      key_d = next_key_i;
      ent_d = next_ent_i;
    end else begin
      key_d = key_q;
      ent_d = ent_q;
      if (wr) ent_d.qty = new_qty;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    ent_q     <= ent_d;
    tok_q     <= tok_d;
    tok_key_q <= tok_key_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_act_q <= 1'b0;
    end else begin
      tok_act_q <= tok_i.active;
    end
  end

  always_comb begin
    tok_o        = tok_q;
    tok_o.active = tok_act_q;
  end

  assign tok_key_o = tok_key_q;
  assign key_o     = key_q;
  assign ent_o     = ent_q;

endmodule

>>> rtl/kbs_ctrl.sv
module kbs_ctrl #(
  parameter int DEPTH    = 64,
  parameter int KEY_BITS = 16,
  parameter int FILL_W   = 7
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  kbs_pkg::kbs_cfg_t         cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [2:0]                cmd_i,
  input  logic [15:0]               item_key_i,
  input  logic [1:0]                category_code_i,
  input  logic signed [31:0]        amount_i,
  input  logic [31:0]               unit_price_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [3:0]                status_o,
  output logic [15:0]               entry_key_o,
  output logic [1:0]                entry_category_o,
  output logic signed [31:0]        entry_quantity_o,
  output logic [31:0]               entry_price_o,
  output logic                      in_stock_o,
  output logic [6:0]                entry_count_o,
  output logic [FILL_W-1:0]         fill_o,
  output kbs_pkg::kbs_shift_t       shift_o,
  output logic [KEY_BITS-1:0]       new_key_o,
  output kbs_pkg::kbs_entry_t       new_ent_o,
  input  logic [KEY_BITS-1:0]       top_key_i,
  input  kbs_pkg::kbs_entry_t       top_ent_i,
  output kbs_pkg::kbs_tok_t         tok_o,
  output logic [KEY_BITS-1:0]       tok_key_o,
  input  kbs_pkg::kbs_tok_t         tail_tok_i
);
  import kbs_pkg::*;

  kbs_state_e state_q, state_d;

  kbs_cmd_e            cmd_q;
  logic [KEY_BITS-1:0] key_q;
  logic [1:0]          cat_q;
  logic signed [31:0]  amount_q;
  logic [31:0]         price_q;
  logic                launch_q;
  kbs_tok_t            hold_q;
  logic [FILL_W-1:0]   fill_q, fill_d;

  logic               out_valid_q;
  kbs_status_e        status_q;
  logic [15:0]        out_key_q;
  logic [1:0]         out_cat_q;
  logic signed [31:0] out_qty_q;
  logic [31:0]        out_price_q;
  logic               out_stock_q;
  logic [6:0]         out_count_q;

  logic [63:0]         in_key_wide;
  logic [KEY_BITS-1:0] in_key;
  kbs_cmd_e            in_cmd;
  logic                in_acc, out_free, reply, full;
  logic [31:0]         limit, cap_wide;

  kbs_status_e         res_status;
  logic [KEY_BITS-1:0] res_key;
  kbs_entry_t          res_ent;
  logic [63:0]         res_key_wide;
  logic [31:0]         fill_wide;
  kbs_shift_t          shift;

  function automatic logic is_keyed(kbs_cmd_e c);
    logic k;
    unique case (c)
      CMD_PUSH, CMD_LOOKUP, CMD_SET, CMD_ADD, CMD_SUB: k = 1'b1;
      default:                                         k = 1'b0;
    endcase
    return k;
  endfunction

  assign in_key_wide = 64'(item_key_i);
  assign in_key      = in_key_wide[KEY_BITS-1:0];
  assign in_cmd      = kbs_cmd_e'(cmd_i);
  assign in_acc      = in_valid_i && (state_q == S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign reply       = (state_q == S_REPLY) && out_free;

  assign cap_wide = 32'(cfg_i.capacity);
  assign limit    = (cap_wide < 32'(DEPTH)) ? cap_wide : 32'(DEPTH);
  assign full     = 32'(fill_q) >= limit;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = is_keyed(in_cmd) ? S_SEARCH : S_REPLY;
      end
      S_SEARCH: begin
        if (tail_tok_i.active) state_d = S_REPLY;
      end
      S_REPLY: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // result and stack moves
  always_comb begin
    res_status = ST_OK;
    res_key    = '0;
    res_ent    = '0;
    shift      = '0;
    fill_d     = fill_q;
    unique case (cmd_q)
      CMD_PUSH: begin
        priority if (hold_q.found) begin
          res_status = ST_DUP;
        end else if (!cfg_i.mask[cat_q]) begin
          res_status = ST_BADCAT;
        end else if (full) begin
          res_status = ST_FULL;
        end else begin
          res_key  = key_q;
          res_ent  = '{cat: cat_q, qty: amount_q, price: price_q};
          shift.dn = reply;
          if (reply) fill_d = fill_q + FILL_W'(1);
        end
      end
      CMD_POP, CMD_PEEK: begin
        if (fill_q == '0) begin
          res_status = ST_EMPTY;
        end else begin
          res_key = top_key_i;
          res_ent = top_ent_i;
          if (cmd_q == CMD_POP) begin
            shift.up = reply;
            if (reply) fill_d = fill_q - FILL_W'(1);
          end
        end
      end
      CMD_LOOKUP, CMD_SET, CMD_ADD, CMD_SUB: begin
        priority if (fill_q == '0) begin
          res_status = ST_EMPTY;
        end else if (!hold_q.found) begin
          res_status = ST_MISSING;
        end else begin
          res_key = key_q;
          res_ent = hold_q.ent;
          priority if (cmd_q != CMD_LOOKUP && amount_q[31]) begin
            res_status = ST_NEGVAL;
          end else if (cmd_q == CMD_SUB && hold_q.negres) begin
            res_status = ST_NEGRES;
          end else if (cmd_q == CMD_ADD && hold_q.ovf) begin
            res_status = ST_OVF;
          end else begin
            res_status = ST_OK;
          end
        end
      end
      default: ;
    endcase
  end

  assign res_key_wide = 64'(res_key);
  assign fill_wide    = 32'(fill_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      launch_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      launch_q <= in_acc && is_keyed(in_cmd);
      if (reply) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q    <= in_cmd;
      key_q    <= in_key;
      cat_q    <= category_code_i;
      amount_q <= amount_i;
      price_q  <= unit_price_i;
    end
    if (state_q == S_SEARCH && tail_tok_i.active) begin
      hold_q <= tail_tok_i;
    end
    if (reply) begin
      status_q    <= res_status;
      out_key_q   <= res_key_wide[15:0];
      out_cat_q   <= res_ent.cat;
      out_qty_q   <= res_ent.qty;
      out_price_q <= res_ent.price;
      out_stock_q <= !res_ent.qty[31] && (res_ent.qty != '0);
      out_count_q <= fill_wide[6:0];
    end
  end

  // new request enters the top cell the cycle after acceptance
  always_comb begin
    tok_o        = '0;
    tok_o.active = launch_q;
    tok_o.cmd    = cmd_q;
    tok_o.amount = amount_q;
  end

  assign tok_key_o = key_q;
  assign new_key_o = key_q;
  assign new_ent_o = '{cat: cat_q, qty: amount_q, price: price_q};
  assign shift_o   = shift;
  assign fill_o    = fill_q;

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign entry_key_o      = out_key_q;
  assign entry_category_o = out_cat_q;
  assign entry_quantity_o = out_qty_q;
  assign entry_price_o    = out_price_q;
  assign in_stock_o       = out_stock_q;
  assign entry_count_o    = out_count_q;

endmodule

>>> verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import kbs_pkg::*;

  localparam int DEPTH = 64;
  localparam int IDLE_PCT = 21;
  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam int NUM_PHASES = 7;

  typedef struct {
    logic [2:0]         cmd;
    logic [15:0]        key;
    logic [1:0]         cat;
    logic signed [31:0] amount;
    logic [31:0]        price;
  } stack_req_t;

  typedef struct {
    kbs_status_e        status;
    logic [15:0]        key;
    logic [1:0]         cat;
    logic signed [31:0] qty;
    logic [31:0]        price;
    logic               in_stock;
    logic [6:0]         count;
  } stack_outcome_t;

  typedef struct {
    stack_req_t     rq;
    bit             typed;
    stack_outcome_t want;
  } script_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [2:0]         cmd_i;
  logic [15:0]        item_key_i;
  logic [1:0]         category_code_i;
  logic signed [31:0] amount_i;
  logic [31:0]        unit_price_i;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [3:0]         status_o;
  logic [15:0]        entry_key_o;
  logic [1:0]         entry_category_o;
  logic signed [31:0] entry_quantity_o;
  logic [31:0]        entry_price_o;
  logic               in_stock_o;
  logic [6:0]         entry_count_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  // shadow copy of the stack and its registers
  logic [15:0]        held_key[DEPTH];
  logic [1:0]         held_cat[DEPTH];
  logic signed [31:0] held_qty[DEPTH];
  logic [31:0]        held_price[DEPTH];
  int                 held_count = 0;
  logic [6:0]         cap_reg = CAPACITY_RST;
  logic [3:0]         mask_reg = MASK_RST;

  stack_outcome_t awaited[$];
  stack_outcome_t head_outcome;
  script_row_t    script[$];
  int             fail_count = 0;
  int             sent_count = 0;
  int             status_seen[9];
  bit             quiet = 1'b0;

  keyed_bounded_stack_core u_dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("keyed_bounded_stack_core test failed");
    $finish;
  end

  function automatic int find_held(logic [15:0] key);
    for (int i = held_count - 1; i >= 0; i--) begin
      if (held_key[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic stack_outcome_t with_entry(stack_outcome_t o, int i);
    o.key      = held_key[i];
    o.cat      = held_cat[i];
    o.qty      = held_qty[i];
    o.price    = held_price[i];
    o.in_stock = held_qty[i] > 0;
    return o;
  endfunction

  // applies one request to the shadow stack and returns the reply it must produce
  function automatic stack_outcome_t stack_outcome(stack_req_t rq);
    stack_outcome_t     o;
    int                 lim;
    int                 slot;
    logic signed [32:0] wide;
    o.status   = ST_OK;
    o.key      = '0;
    o.cat      = '0;
    o.qty      = '0;
    o.price    = '0;
    o.in_stock = 1'b0;
    lim = (int'(cap_reg) < DEPTH) ? int'(cap_reg) : DEPTH;
    unique case (rq.cmd)
      CMD_PUSH: begin
        if (find_held(rq.key) >= 0) o.status = ST_DUP;
        else if (!mask_reg[rq.cat]) o.status = ST_BADCAT;
        else if (held_count >= lim) o.status = ST_FULL;
        else begin
          held_key[held_count]   = rq.key;
          held_cat[held_count]   = rq.cat;
          held_qty[held_count]   = rq.amount;
          held_price[held_count] = rq.price;
          o = with_entry(o, held_count);
          held_count++;
        end
      end
      CMD_POP, CMD_PEEK: begin
        if (held_count == 0) o.status = ST_EMPTY;
        else begin
          o = with_entry(o, held_count - 1);
          if (rq.cmd == CMD_POP) held_count--;
        end
      end
      CMD_LOOKUP, CMD_SET, CMD_ADD, CMD_SUB: begin
        slot = find_held(rq.key);
        if (held_count == 0) o.status = ST_EMPTY;
        else if (slot < 0) o.status = ST_MISSING;
        else begin
          if (rq.cmd != CMD_LOOKUP) begin
            wide = held_qty[slot];
            if (rq.amount < 0) o.status = ST_NEGVAL;
            else if (rq.cmd == CMD_SET) held_qty[slot] = rq.amount;
            else if (rq.cmd == CMD_ADD) begin
              wide = wide + rq.amount;
              if (wide > QTY_MAX) begin
                wide = QTY_MAX;
                o.status = ST_OVF;
              end
              held_qty[slot] = wide[31:0];
            end else begin
              wide = wide - rq.amount;
              if (wide < 0) o.status = ST_NEGRES;
              else held_qty[slot] = wide[31:0];
            end
          end
          o = with_entry(o, slot);
        end
      end
      default: ;
    endcase
    o.count = held_count[6:0];
    return o;
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic stack_req_t mk_req(logic [2:0] cmd, logic [15:0] key, logic [1:0] cat,
                                        logic signed [31:0] amount, logic [31:0] price);
    stack_req_t rq;
    rq.cmd    = cmd;
    rq.key    = key;
    rq.cat    = cat;
    rq.amount = amount;
    rq.price  = price;
    return rq;
  endfunction

  function automatic script_row_t typed_row(stack_req_t rq, kbs_status_e st, logic [15:0] key,
                                            logic [1:0] cat, logic signed [31:0] qty,
                                            logic [31:0] price, logic stock,
                                            logic [6:0] count);
    script_row_t row;
    row.rq             = rq;
    row.typed          = 1'b1;
    row.want.status    = st;
    row.want.key       = key;
    row.want.cat       = cat;
    row.want.qty       = qty;
    row.want.price     = price;
    row.want.in_stock  = stock;
    row.want.count     = count;
    return row;
  endfunction

  function automatic script_row_t model_row(stack_req_t rq);
    script_row_t row;
    row.rq    = rq;
    row.typed = 1'b0;
    return row;
  endfunction

  // enters at a falling edge, leaves at the falling edge after acceptance
  task automatic send_request(stack_req_t rq, bit typed, stack_outcome_t fixed);
    stack_outcome_t o;
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    cmd_i           <= rq.cmd;
    item_key_i      <= rq.key;
    category_code_i <= rq.cat;
    amount_i        <= rq.amount;
    unit_price_i    <= rq.price;
    in_valid_i      <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    o = stack_outcome(rq);
    awaited.push_back(typed ? fixed : o);
    sent_count++;
    @(negedge clk_i);
  endtask

  task automatic drain_replies();
    in_valid_i <= 1'b0;
    while (awaited.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // APB write followed by a read back of the same register
  task automatic set_register(logic idx, logic [31:0] value);
    logic [31:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_CAPACITY) begin
      cap_reg = value[6:0];
      want = {25'd0, value[6:0]};
    end else begin
      mask_reg = value[3:0];
      want = {28'd0, value[3:0]};
    end
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    compare_field("prdata", want, prdata);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited.size() == 0) begin
        $error("reply with no request pending: status %0d key %h", status_o, entry_key_o);
        fail_count++;
      end else begin
        head_outcome = awaited.pop_front();
        compare_field("status", 32'(head_outcome.status), 32'(status_o));
        compare_field("entry_key", 32'(head_outcome.key), 32'(entry_key_o));
        compare_field("entry_category", 32'(head_outcome.cat), 32'(entry_category_o));
        compare_field("entry_quantity", head_outcome.qty, entry_quantity_o);
        compare_field("entry_price", head_outcome.price, entry_price_o);
        compare_field("in_stock", 32'(head_outcome.in_stock), 32'(in_stock_o));
        compare_field("entry_count", 32'(head_outcome.count), 32'(entry_count_o));
        if (status_o < 9) status_seen[status_o]++;
      end
    end
  end

  initial begin
    int             ph_len[NUM_PHASES]  = '{120, 80, 40, 60, 150, 150, 125};
    int             ph_cap[NUM_PHASES]  = '{127, 10, 0, 1, 64, 100, -1};
    int             ph_mask[NUM_PHASES] = '{15, 15, 0, 1, 7, 10, -1};
    int             ph_push[NUM_PHASES] = '{75, 30, 10, 40, 35, 35, 35};
    int             ph_pop[NUM_PHASES]  = '{3, 25, 60, 20, 10, 10, 10};
    stack_req_t     rq;
    stack_outcome_t unused_outcome;
    int             r;
    int             key_pct;

    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    cmd_i           = CMD_PUSH;
    item_key_i      = '0;
    category_code_i = '0;
    amount_i        = '0;
    unit_price_i    = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty-stack replies, extremes of every field, each status code but full
    script.push_back(typed_row(mk_req(CMD_POP, 16'h0000, 2'd0, 0, 0),
                               ST_EMPTY, 16'h0, 2'd0, 0, 0, 1'b0, 7'd0));
    script.push_back(typed_row(mk_req(CMD_PEEK, 16'h0000, 2'd0, 0, 0),
                               ST_EMPTY, 16'h0, 2'd0, 0, 0, 1'b0, 7'd0));
    script.push_back(typed_row(mk_req(CMD_LOOKUP, 16'hFFFF, 2'd3, 0, 0),
                               ST_EMPTY, 16'h0, 2'd0, 0, 0, 1'b0, 7'd0));
    script.push_back(typed_row(mk_req(CMD_ADD, 16'h0000, 2'd0, 5, 0),
                               ST_EMPTY, 16'h0, 2'd0, 0, 0, 1'b0, 7'd0));
    script.push_back(typed_row(mk_req(CMD_SUB, 16'h0000, 2'd0, 5, 0),
                               ST_EMPTY, 16'h0, 2'd0, 0, 0, 1'b0, 7'd0));
    script.push_back(typed_row(mk_req(CMD_UNUSED, 16'hFFFF, 2'd3, -1, 32'hFFFF_FFFF),
                               ST_OK, 16'h0, 2'd0, 0, 0, 1'b0, 7'd0));
    script.push_back(typed_row(mk_req(CMD_PUSH, 16'hFFFF, 2'd0, QTY_MAX, 32'hFFFF_FFFF),
                               ST_OK, 16'hFFFF, 2'd0, QTY_MAX, 32'hFFFF_FFFF, 1'b1, 7'd1));
    script.push_back(typed_row(mk_req(CMD_PUSH, 16'h0000, 2'd3, 1, 1),
                               ST_BADCAT, 16'h0, 2'd0, 0, 0, 1'b0, 7'd1));
    script.push_back(typed_row(mk_req(CMD_PUSH, 16'hFFFF, 2'd1, 1, 1),
                               ST_DUP, 16'h0, 2'd0, 0, 0, 1'b0, 7'd1));
    script.push_back(typed_row(mk_req(CMD_PUSH, 16'h0000, 2'd2, 32'sh8000_0000, 0),
                               ST_OK, 16'h0, 2'd2, 32'sh8000_0000, 0, 1'b0, 7'd2));
    script.push_back(model_row(mk_req(CMD_PUSH, 16'h0001, 2'd1, 0, 100)));
    script.push_back(model_row(mk_req(CMD_ADD, 16'hFFFF, 2'd0, 1, 0)));
    script.push_back(model_row(mk_req(CMD_ADD, 16'h0000, 2'd0, 5, 0)));
    script.push_back(model_row(mk_req(CMD_SUB, 16'h0001, 2'd0, 1, 0)));
    script.push_back(model_row(mk_req(CMD_SET, 16'h0001, 2'd0, -1, 0)));
    script.push_back(model_row(mk_req(CMD_SET, 16'h0001, 2'd0, 10, 0)));
    script.push_back(model_row(mk_req(CMD_SUB, 16'h0001, 2'd0, 10, 0)));
    script.push_back(model_row(mk_req(CMD_LOOKUP, 16'h1234, 2'd0, 0, 0)));
    script.push_back(model_row(mk_req(CMD_LOOKUP, 16'h0000, 2'd0, 0, 0)));
    // stored quantity is negative, so even a zero subtract goes below zero
    script.push_back(model_row(mk_req(CMD_SUB, 16'h0000, 2'd0, 0, 0)));
    script.push_back(model_row(mk_req(CMD_ADD, 16'h0001, 2'd0, QTY_MAX, 0)));
    script.push_back(model_row(mk_req(CMD_PEEK, 16'h0000, 2'd0, 0, 0)));
    script.push_back(model_row(mk_req(CMD_UNUSED, 16'h0000, 2'd0, 0, 0)));
    script.push_back(model_row(mk_req(CMD_POP, 16'h0000, 2'd0, 0, 0)));
    script.push_back(model_row(mk_req(CMD_POP, 16'h0000, 2'd0, 0, 0)));

    foreach (script[i]) send_request(script[i].rq, script[i].typed, script[i].want);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_replies();
      set_register(REG_CAPACITY, (ph_cap[p] < 0) ? $urandom_range(0, 127) : ph_cap[p]);
      set_register(REG_MASK, (ph_mask[p] < 0) ? $urandom_range(0, 15) : ph_mask[p]);
      quiet = (p == 5);
      for (int n = 0; n < ph_len[p]; n++) begin
        r = $urandom_range(0, 99);
        if (r < ph_push[p]) rq.cmd = CMD_PUSH;
        else if (r < ph_push[p] + ph_pop[p]) rq.cmd = CMD_POP;
        else begin
          r = $urandom_range(0, 19);
          if (r < 2) rq.cmd = CMD_PEEK;
          else if (r < 6) rq.cmd = CMD_LOOKUP;
          else if (r < 9) rq.cmd = CMD_SET;
          else if (r < 14) rq.cmd = CMD_ADD;
          else if (r < 19) rq.cmd = CMD_SUB;
          else rq.cmd = CMD_UNUSED;
        end
        // updates mostly hit held keys; pushes mostly bring new ones
        key_pct = (rq.cmd == CMD_PUSH) ? 10 : 55;
        r = $urandom_range(0, 99);
        if (held_count > 0 && r < key_pct) rq.key = held_key[$urandom_range(0, held_count - 1)];
        else if (r < key_pct + 7) rq.key = r[0] ? 16'hFFFF : 16'h0000;
        else rq.key = 16'($urandom);
        rq.cat = 2'($urandom_range(0, 3));
        r = $urandom_range(0, 99);
        if (r < 60) rq.amount = $urandom_range(0, 1000);
        else if (r < 72) rq.amount = -int'($urandom_range(1, 1000));
        else if (r < 85) rq.amount = $urandom_range(32'h7FFF_0000, 32'h7FFF_FFFF);
        else rq.amount = $urandom;
        rq.price = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 5_000_000) : $urandom;
        send_request(rq, 1'b0, unused_outcome);
      end
    end

    quiet = 1'b0;
    in_valid_i <= 1'b0;
    while (awaited.size() != 0) @(negedge clk_i);
    repeat (2 * DEPTH) @(negedge clk_i);

    $display("Ran %0d requests over %0d register settings, stack held %0d at the end.",
             sent_count, NUM_PHASES + 1, held_count);
    $display("Status counts ok..ovf: %0d %0d %0d %0d %0d %0d %0d %0d %0d",
             status_seen[ST_OK], status_seen[ST_DUP], status_seen[ST_BADCAT],
             status_seen[ST_FULL], status_seen[ST_EMPTY], status_seen[ST_MISSING],
             status_seen[ST_NEGVAL], status_seen[ST_NEGRES], status_seen[ST_OVF]);
    if (fail_count == 0) begin
      $display("keyed_bounded_stack_core test passed");
    end else begin
      $display("keyed_bounded_stack_core test failed");
    end
    $finish;
  end

endmodule
